// ----- src/button_debounce_click_detector_assert.svh -----
// assertion macros for the checker file of the button debounce block
// depends on nothing; included by bare file name
`ifndef BUTTON_DEBOUNCE_CLICK_DETECTOR_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_DETECTOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BDCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BDCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bdcd_pkg.sv -----
// shared types and constants of the button debounce and click detector
// depends on nothing
package bdcd_pkg;

   // payload widths
   localparam int unsigned IndexW   = 4;
   localparam int unsigned TimeW    = 32;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned CsrIndexW = 2;
   localparam int unsigned CountW   = 2;

   // number of buttons an index can address
   localparam int unsigned ButtonSlots = 2 ** IndexW;

   // default for the top level parameter
   localparam int unsigned BUTTON_COUNT_DEF = 16;

   // register reset values
   localparam logic [CsrDataW-1:0] DebounceReset    = 16'd50;
   localparam logic [CsrDataW-1:0] ClickWindowReset = 16'd400;
   localparam logic [CsrDataW-1:0] LongPressReset   = 16'd800;
   localparam logic [CsrDataW-1:0] ActiveHighReset  = 16'hFFFF;

   // saturation point and the single- and double-click counts
   localparam logic [CountW-1:0] CountMax    = 2'd3;
   localparam logic [CountW-1:0] CountSingle = 2'd1;
   localparam logic [CountW-1:0] CountDouble = 2'd2;

   typedef enum logic [2:0] {
      CLICK_IDLE     = 3'd0,
      CLICK_DOWN     = 3'd1,
      CLICK_UP       = 3'd2,
      CLICK_COUNT    = 3'd3,
      CLICK_HELD     = 3'd4,
      CLICK_HELD_END = 3'd5
   } click_state_type;

   typedef enum logic [1:0] {
      EVENT_NONE   = 2'd0,
      EVENT_SINGLE = 2'd1,
      EVENT_DOUBLE = 2'd2,
      EVENT_LONG   = 2'd3
   } event_code_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_DEBOUNCE_TIME    = 2'd0,
      CSR_CLICK_WINDOW     = 2'd1,
      CSR_LONG_PRESS_TIME  = 2'd2,
      CSR_ACTIVE_HIGH_MASK = 2'd3
   } csr_reg_type;

endpackage

// ----- src/button_debounce_click_detector.sv -----
// top level of the button debounce and click detector
// depends on bdcd_pkg
//
// Takes one raw level sample word per cycle while req_stall is low, each
// naming a button and a millisecond timestamp, and returns exactly one
// result word per sample, in order: the button's debounced level and any
// click event (single, double or long press). A sample sits in an input
// register; combinational logic does the read-modify-write of that button's
// state and loads the output register, so back-to-back samples of the same
// button see each other's updates. Only buttons below BUTTON_COUNT (at most
// 16 reachable) keep state; others return level 0 and no event. Registers
// are written through the csr port, which is always ready; the user must
// write them only while no sample is in flight, as the block itself does
// not enforce it.
module button_debounce_click_detector #(
   parameter int unsigned BUTTON_COUNT = bdcd_pkg::BUTTON_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bdcd_pkg::IndexW-1:0]     req_button_index,
   input  logic                            req_raw_level,
   input  logic [bdcd_pkg::TimeW-1:0]      req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bdcd_pkg::IndexW-1:0]     rsp_button_id,
   output logic                            rsp_stable_level,
   output logic [1:0]                      rsp_event_code,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bdcd_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [bdcd_pkg::CsrDataW-1:0]   csr_wdata
);

   localparam int unsigned Depth = (BUTTON_COUNT < bdcd_pkg::ButtonSlots) ?
                                   BUTTON_COUNT : bdcd_pkg::ButtonSlots;
   localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned PadW  = bdcd_pkg::TimeW - bdcd_pkg::CsrDataW;

   // configuration registers
   logic [bdcd_pkg::CsrDataW-1:0] debounce_time_ff, click_window_ff;
   logic [bdcd_pkg::CsrDataW-1:0] long_press_time_ff, active_high_mask_ff;

   // input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [bdcd_pkg::IndexW-1:0]   s1_index_ff;
   logic                          s1_level_ff;
   logic [bdcd_pkg::TimeW-1:0]    s1_now_ff;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bdcd_pkg::IndexW-1:0]     rsp_id_ff;
   logic                            rsp_level_ff, rsp_level_in;
   bdcd_pkg::event_code_type        rsp_event_ff, rsp_event_in;

   // per-button state
   bdcd_pkg::click_state_type     click_state_ff [Depth];
   logic [bdcd_pkg::CountW-1:0]   click_count_ff [Depth];
   logic [bdcd_pkg::TimeW-1:0]    phase_start_ff [Depth];
   logic [bdcd_pkg::TimeW-1:0]    last_change_ff [Depth];
   logic                          last_raw_ff    [Depth];
   logic                          stable_raw_ff  [Depth];

   // next values of the addressed button
   bdcd_pkg::click_state_type     click_state_in;
   logic [bdcd_pkg::CountW-1:0]   click_count_in;
   logic [bdcd_pkg::TimeW-1:0]    phase_start_in;
   logic [bdcd_pkg::TimeW-1:0]    last_change_in;
   logic                          last_raw_in;
   logic                          stable_raw_in;

   logic                          s1_adv, req_take, rsp_take, in_range, pressed;
   logic [IdxW-1:0]               slot;
   logic [bdcd_pkg::TimeW-1:0]    since_change, elapsed;
   bdcd_pkg::event_code_type      event_val;

   // handshake
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_take ? 1'b0 : rsp_valid_ff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_id    = rsp_id_ff;
   assign rsp_stable_level = rsp_level_ff;
   assign rsp_event_code   = rsp_event_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff    <= bdcd_pkg::DebounceReset;
         click_window_ff     <= bdcd_pkg::ClickWindowReset;
         long_press_time_ff  <= bdcd_pkg::LongPressReset;
         active_high_mask_ff <= bdcd_pkg::ActiveHighReset;
      end else if (csr_valid && csr_ready) begin
         case (bdcd_pkg::csr_reg_type'(csr_index))
            bdcd_pkg::CSR_DEBOUNCE_TIME:    debounce_time_ff    <= csr_wdata;
            bdcd_pkg::CSR_CLICK_WINDOW:     click_window_ff     <= csr_wdata;
            bdcd_pkg::CSR_LONG_PRESS_TIME:  long_press_time_ff  <= csr_wdata;
            bdcd_pkg::CSR_ACTIVE_HIGH_MASK: active_high_mask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // addressed button
   assign in_range = 32'(s1_index_ff) < BUTTON_COUNT;
   assign slot     = s1_index_ff[IdxW-1:0];

   // debouncer and click machine for the addressed button
   always_comb begin
      click_state_in = click_state_ff[slot];
      click_count_in = click_count_ff[slot];
      phase_start_in = phase_start_ff[slot];
      last_change_in = last_change_ff[slot];
      last_raw_in    = last_raw_ff[slot];
      stable_raw_in  = stable_raw_ff[slot];
      event_val      = bdcd_pkg::EVENT_NONE;
      since_change   = s1_now_ff - last_change_ff[slot];
      elapsed        = s1_now_ff - phase_start_ff[slot];

      // raw level must hold for the debounce time before it is taken
      if (last_raw_ff[slot] == s1_level_ff) begin
         if (since_change >= {{PadW{1'b0}}, debounce_time_ff}) begin
            stable_raw_in = s1_level_ff;
         end
      end else begin
         last_change_in = s1_now_ff;
         last_raw_in    = s1_level_ff;
      end

      pressed = stable_raw_in == active_high_mask_ff[s1_index_ff];

      case (click_state_ff[slot])
         bdcd_pkg::CLICK_IDLE: begin
            if (pressed) begin
               click_state_in = bdcd_pkg::CLICK_DOWN;
               phase_start_in = s1_now_ff;
               click_count_in = '0;
            end
         end
         bdcd_pkg::CLICK_DOWN: begin
            if (!pressed) begin
               click_state_in = bdcd_pkg::CLICK_UP;
               phase_start_in = s1_now_ff;
            end else if (elapsed > {{PadW{1'b0}}, long_press_time_ff}) begin
               event_val      = bdcd_pkg::EVENT_LONG;
               click_state_in = bdcd_pkg::CLICK_HELD;
            end
         end
         bdcd_pkg::CLICK_UP: begin
            if (click_count_ff[slot] != bdcd_pkg::CountMax) begin
               click_count_in = click_count_ff[slot] + 1'b1;
            end
            click_state_in = bdcd_pkg::CLICK_COUNT;
         end
         bdcd_pkg::CLICK_COUNT: begin
            if (pressed) begin
               click_state_in = bdcd_pkg::CLICK_DOWN;
               phase_start_in = s1_now_ff;
            end else if (elapsed >= {{PadW{1'b0}}, click_window_ff} ||
                         click_count_ff[slot] == bdcd_pkg::CountDouble) begin
               if (click_count_ff[slot] == bdcd_pkg::CountSingle) begin
                  event_val = bdcd_pkg::EVENT_SINGLE;
               end else if (click_count_ff[slot] == bdcd_pkg::CountDouble) begin
                  event_val = bdcd_pkg::EVENT_DOUBLE;
               end
               click_state_in = bdcd_pkg::CLICK_IDLE;
               click_count_in = '0;
               phase_start_in = '0;
            end
         end
         bdcd_pkg::CLICK_HELD: begin
            if (!pressed) begin
               click_state_in = bdcd_pkg::CLICK_HELD_END;
               phase_start_in = s1_now_ff;
            end
         end
         bdcd_pkg::CLICK_HELD_END: begin
            click_state_in = bdcd_pkg::CLICK_IDLE;
            click_count_in = '0;
            phase_start_in = '0;
         end
         default: begin
            click_state_in = bdcd_pkg::CLICK_IDLE;
         end
      endcase

      // buttons beyond the configured count report level 0 and no event
      rsp_level_in = in_range ? stable_raw_in : 1'b0;
      rsp_event_in = in_range ? event_val : bdcd_pkg::EVENT_NONE;
   end

   // per-button state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            click_state_ff[i] <= bdcd_pkg::CLICK_IDLE;
            click_count_ff[i] <= '0;
            phase_start_ff[i] <= '0;
            last_change_ff[i] <= '0;
            last_raw_ff[i]    <= 1'b0;
            stable_raw_ff[i]  <= 1'b0;
         end
      end else if (s1_adv && in_range) begin
         click_state_ff[slot] <= click_state_in;
         click_count_ff[slot] <= click_count_in;
         phase_start_ff[slot] <= phase_start_in;
         last_change_ff[slot] <= last_change_in;
         last_raw_ff[slot]    <= last_raw_in;
         stable_raw_ff[slot]  <= stable_raw_in;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_index_ff <= req_button_index;
         s1_level_ff <= req_raw_level;
         s1_now_ff   <= req_now_ms;
      end
   end

   // result word capture
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_id_ff    <= s1_index_ff;
         rsp_level_ff <= rsp_level_in;
         rsp_event_ff <= rsp_event_in;
      end
   end

endmodule

// ----- src/bdcd_checker.sv -----
// port-level checks of the button debounce and click detector, with its bind
// depends on bdcd_pkg and button_debounce_click_detector_assert.svh
`include "button_debounce_click_detector_assert.svh"

module bdcd_checker #(
   parameter int unsigned BUTTON_COUNT = bdcd_pkg::BUTTON_COUNT_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bdcd_pkg::IndexW-1:0]    rsp_button_id,
   input logic                           rsp_stable_level,
   input logic [1:0]                     rsp_event_code
);

   // a result only shows up once an accepted word has passed the input register
   `BDCD_ASSERT_SAME(a_rsp_has_source, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without an accepted sample")

   // the input only stalls while the result register is full and held
   `BDCD_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled with room downstream")

   // unknown buttons report level 0 and no event
   `BDCD_ASSERT_SAME(a_unknown_button_quiet, clock, reset, rsp_valid && (32'(rsp_button_id) >= BUTTON_COUNT), !rsp_stable_level && rsp_event_code == bdcd_pkg::EVENT_NONE, "unknown button reported activity")

   // a held result stays put
   `BDCD_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_button_id) && $stable(rsp_stable_level) && $stable(rsp_event_code), "stalled result changed")

endmodule

bind button_debounce_click_detector bdcd_checker #(
   .BUTTON_COUNT(BUTTON_COUNT)
) u_bdcd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_button_id    (rsp_button_id),
   .rsp_stable_level (rsp_stable_level),
   .rsp_event_code   (rsp_event_code)
);
